FILE: src/priority_subscriber_table_unit_macros.svh
// Assertion macros shared by the subscriber table RTL.
`ifndef PRIORITY_SUBSCRIBER_TABLE_UNIT_MACROS_SVH
`define PRIORITY_SUBSCRIBER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PSUB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PSUB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/psub_pkg.sv
// Types and constants of the priority subscriber table.
package psub_pkg;

  localparam int EVENT_KINDS     = 16;
  localparam int SLOTS_PER_EVENT = 4;
  localparam int KIND_W          = 4;
  localparam int ID_W            = 8;
  localparam int PRIO_W          = 8;
  localparam int DATA_W          = 32;
  localparam int STATUS_W        = 3;
  localparam int CNT_W           = $clog2(SLOTS_PER_EVENT + 1);
  localparam int SLOT_IDX_W      = (SLOTS_PER_EVENT > 1) ? $clog2(SLOTS_PER_EVENT) : 1;
  localparam int ROW_IDX_W       = (EVENT_KINDS > 1) ? $clog2(EVENT_KINDS) : 1;

  localparam logic [PRIO_W-1:0] EMPTY_PRIO = PRIO_W'(255);

  typedef enum logic [1:0] {
    ACT_SUBSCRIBE = 2'd0,
    ACT_CANCEL    = 2'd1,
    ACT_DISPATCH  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_DELIVERED = 3'd3,
    ST_NOSUBS    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  // One memory row holds the whole list of one event kind.
  typedef struct packed {
    logic [CNT_W-1:0]                           cnt;
    logic [SLOTS_PER_EVENT-1:0][ID_W-1:0]       ids;
    logic [SLOTS_PER_EVENT-1:0][PRIO_W-1:0]     prios;
  } row_t;

  localparam row_t RESET_ROW = '{
    cnt:   '0,
    ids:   '0,
    prios: {SLOTS_PER_EVENT{EMPTY_PRIO}}
  };

endpackage

FILE: src/priority_subscriber_table_unit.sv
// Priority subscriber table: per-kind sorted subscriber lists in a row memory.
//
// Each event kind owns one row of a single-port synchronous memory holding its
// sorted subscriber list and fill count. A request is taken in the idle state;
// its row is read on the accepting edge, modified and written back in the next
// cycle, and the results then leave through an output register. Subscribe,
// cancel and unused action codes give one result each; a dispatch gives one
// result per subscriber (one when the list is empty), one result per cycle
// while the output is not stalled. Rows carry valid bits cleared by reset, and
// a row never written reads as an empty list, so no clearing pass follows
// reset. The next request is accepted as soon as the final result sits in the
// output register.
module priority_subscriber_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [psub_pkg::KIND_W-1:0]  in_event_kind,
  input  logic [psub_pkg::PRIO_W-1:0]  in_priority_req,
  input  logic [psub_pkg::ID_W-1:0]    in_subscriber_id,
  input  logic [psub_pkg::DATA_W-1:0]  in_aux_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [psub_pkg::STATUS_W-1:0] out_status,
  output logic [psub_pkg::ID_W-1:0]    out_target_id,
  output logic [psub_pkg::KIND_W-1:0]  out_delivered_kind,
  output logic [psub_pkg::DATA_W-1:0]  out_delivered_data,
  output logic                         out_last
);
  import psub_pkg::*;
  `include "priority_subscriber_table_unit_macros.svh"

  state_t state_r, state_nxt;

  // Request registers.
  logic [1:0]            act_r;
  logic [KIND_W-1:0]     kind_r;
  logic                  kind_ok_r;
  logic [PRIO_W-1:0]     prio_r;
  logic [ID_W-1:0]       id_r;
  logic [DATA_W-1:0]     aux_r;

  // Row memory and per-row valid bits.
  row_t                   mem [EVENT_KINDS];
  logic [EVENT_KINDS-1:0] row_vld_r;
  row_t                   rdata_r;
  logic                   rd_vld_r;
  logic                   mem_we;
  row_t                   wdata;
  logic [ROW_IDX_W-1:0]   wr_addr;

  // Result sequencing.
  logic                  disp_r;
  status_t               res_status_r;
  logic [SLOT_IDX_W-1:0] last_idx_r;
  logic [SLOT_IDX_W-1:0] idx_r;

  // Output register.
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ID_W-1:0]       out_id_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [DATA_W-1:0]     out_data_r;
  logic                  out_last_r;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  emit_last;
  row_t                  cur_row;
  row_t                  new_row;
  status_t               exec_status;
  logic                  exec_write;
  logic [CNT_W-1:0]      ins_pos;
  logic [CNT_W-1:0]      hit_pos;
  logic                  hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cur_row   = (kind_ok_r && rd_vld_r) ? rdata_r : RESET_ROW;
  assign emit_last = (idx_r == last_idx_r);
  assign wr_addr   = ROW_IDX_W'(kind_r);

  // List edit: insertion point after equal priorities, first matching id.
  always_comb begin
    ins_pos = '0;
    hit_pos = '0;
    hit     = 1'b0;
    for (int j = 0; j < SLOTS_PER_EVENT; j++) begin
      if (CNT_W'(j) < cur_row.cnt && cur_row.prios[j] <= prio_r) begin
        ins_pos = ins_pos + 1'b1;
      end
      if (!hit && CNT_W'(j) < cur_row.cnt && cur_row.ids[j] == id_r) begin
        hit     = 1'b1;
        hit_pos = CNT_W'(j);
      end
    end

    new_row     = cur_row;
    exec_status = ST_DONE;
    exec_write  = 1'b0;
    case (act_r)
      ACT_SUBSCRIBE: begin
        if (!kind_ok_r || cur_row.cnt >= CNT_W'(SLOTS_PER_EVENT)) begin
          exec_status = ST_FULL;
        end else begin
          for (int j = 1; j < SLOTS_PER_EVENT; j++) begin
            if (CNT_W'(j) > ins_pos && CNT_W'(j) <= cur_row.cnt) begin
              new_row.ids[j]   = cur_row.ids[j-1];
              new_row.prios[j] = cur_row.prios[j-1];
            end
          end
          new_row.ids[SLOT_IDX_W'(ins_pos)]   = id_r;
          new_row.prios[SLOT_IDX_W'(ins_pos)] = prio_r;
          new_row.cnt = cur_row.cnt + 1'b1;
          exec_write  = 1'b1;
        end
      end
      ACT_CANCEL: begin
        if (!kind_ok_r || !hit) begin
          exec_status = ST_NOTFOUND;
        end else begin
          for (int j = 0; j < SLOTS_PER_EVENT - 1; j++) begin
            if (CNT_W'(j) >= hit_pos && CNT_W'(j) + 1'b1 < cur_row.cnt) begin
              new_row.ids[j]   = cur_row.ids[j+1];
              new_row.prios[j] = cur_row.prios[j+1];
            end
          end
          // The slot freed at the tail returns to its empty value.
          new_row.ids[SLOT_IDX_W'(cur_row.cnt - 1'b1)]   = '0;
          new_row.prios[SLOT_IDX_W'(cur_row.cnt - 1'b1)] = EMPTY_PRIO;
          new_row.cnt = cur_row.cnt - 1'b1;
          exec_write  = 1'b1;
        end
      end
      ACT_DISPATCH: begin
        exec_status = (cur_row.cnt == '0) ? ST_NOSUBS : ST_DELIVERED;
      end
      default: begin
        exec_status = ST_DONE;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    wdata     = new_row;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        mem_we    = exec_write;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Row memory: read on the accepting edge, written back from the edit stage.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rdata_r <= mem[ROW_IDX_W'(in_event_kind)];
    end
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r     <= in_action;
      kind_r    <= in_event_kind;
      kind_ok_r <= (int'(in_event_kind) < EVENT_KINDS);
      prio_r    <= in_priority_req;
      id_r      <= in_subscriber_id;
      aux_r     <= in_aux_data;
      rd_vld_r  <= row_vld_r[ROW_IDX_W'(in_event_kind)];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      disp_r       <= (exec_status == ST_DELIVERED);
      res_status_r <= exec_status;
      last_idx_r   <= (exec_status == ST_DELIVERED) ?
                      SLOT_IDX_W'(cur_row.cnt - 1'b1) : '0;
      idx_r        <= '0;
    end else if (out_load) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_last_r   <= emit_last;
      if (disp_r) begin
        out_id_r   <= cur_row.ids[idx_r];
        out_kind_r <= kind_r;
        out_data_r <= aux_r;
      end else begin
        out_id_r   <= '0;
        out_kind_r <= '0;
        out_data_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_target_id      = out_id_r;
  assign out_delivered_kind = out_kind_r;
  assign out_delivered_data = out_data_r;
  assign out_last           = out_last_r;

  `PSUB_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_accept, state_r == S_EXEC,
    "accepted request did not enter the edit stage")
  `PSUB_ASSERT_NOW(a_write_in_exec, clk, rst_n, mem_we, state_r == S_EXEC,
    "row memory written outside the edit stage")
  `PSUB_ASSERT_NOW(a_count_bound, clk, rst_n, state_r == S_EXEC,
    cur_row.cnt <= CNT_W'(SLOTS_PER_EVENT), "list count beyond the row size")
  `PSUB_ASSERT_NOW(a_single_last, clk, rst_n,
    out_valid && out_status != ST_DELIVERED, out_last,
    "non-delivery result not marked last")
  `PSUB_ASSERT_NEXT(a_done_on_last, clk, rst_n, out_load && emit_last,
    state_r == S_IDLE, "sequencer did not return to idle after the final result")

endmodule
